// ----- rtl/fuzzy_oa_pkg.sv -----
// ----------------------------------------------------------------------------
// fuzzy_oa_pkg
// Shared types, widths and rule tables for the fuzzy obstacle avoidance core.
// ----------------------------------------------------------------------------
`default_nettype none

package fuzzy_oa_pkg;

    // input distance width, unsigned Q4.8 metres
    localparam int DISTANCE_BITS = 12;

    // grade width, Q1.8 with 256 = 1.0
    localparam int GRADE_W = 9;
    localparam int RULES   = 16;
    localparam int SENSORS = 4;

    // accumulated numerator and denominator widths
    localparam int NUM_W = 25;
    localparam int DEN_W = 13;
    localparam int MAG_W = NUM_W - 1;

    // quotient magnitude width, one divider stage per bit
    localparam int Q_W        = 12;
    localparam int DIV_STAGES = Q_W;

    // result widths
    localparam int WHEEL_W = 14;
    localparam int FWD_W   = 15;
    localparam int TURN_W  = 16;
    localparam int CONS_W  = 14;

    localparam logic [DISTANCE_BITS-1:0] ONE_M   = DISTANCE_BITS'(256);
    localparam logic [DISTANCE_BITS-1:0] THREE_M = DISTANCE_BITS'(768);
    localparam logic [GRADE_W-1:0]       GRADE_ONE = GRADE_W'(256);
    localparam logic [DEN_W-1:0]         MIN_DEN   = DEN_W'(128);

    localparam logic signed [FWD_W-1:0]  FWD_MAX  = FWD_W'(8192);
    localparam logic signed [FWD_W-1:0]  FWD_MIN  = -FWD_W'(8192);
    localparam logic signed [TURN_W-1:0] TURN_MAX = TURN_W'(16384);
    localparam logic signed [TURN_W-1:0] TURN_MIN = -TURN_W'(16384);

    typedef logic [DISTANCE_BITS-1:0] dist_t;
    typedef logic [GRADE_W-1:0]       grade_t;
    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic [DEN_W-1:0]         den_t;
    typedef logic signed [CONS_W-1:0] cons_t;

    // one beat through the queue between front and back
    typedef struct packed {
        num_t num_l;
        num_t num_r;
        den_t den;
    } sums_t;

    // rule consequents, Q.12; bit 3 of the rule index picks left near, bit 0 rear near
    localparam cons_t LEFT_TABLE [RULES] = '{
        CONS_W'(2048), CONS_W'(2048), -CONS_W'(1229), -CONS_W'(1229),
        CONS_W'(410),  CONS_W'(410),  -CONS_W'(1229), -CONS_W'(1229),
        CONS_W'(1229), CONS_W'(1229), CONS_W'(1229),  CONS_W'(1229),
        CONS_W'(1229), CONS_W'(1229), -CONS_W'(1229), -CONS_W'(1229)
    };

    localparam cons_t RIGHT_TABLE [RULES] = '{
        CONS_W'(2048), CONS_W'(2048), CONS_W'(1024),  CONS_W'(1024),
        CONS_W'(1024), CONS_W'(1024), CONS_W'(1024),  CONS_W'(1024),
        CONS_W'(410),  CONS_W'(410),  -CONS_W'(1024), -CONS_W'(1024),
        CONS_W'(1024), CONS_W'(1024), CONS_W'(1024),  CONS_W'(1024)
    };

    // near membership: full below 1 m, zero from 3 m, linear ramp between
    function automatic grade_t near_grade(input dist_t d);
        logic [DISTANCE_BITS:0] ramp;
        ramp = (DISTANCE_BITS+1)'(384) - (DISTANCE_BITS+1)'(d >> 1);
        if (d <= ONE_M)
            return GRADE_ONE;
        else if (d >= THREE_M)
            return '0;
        else
            return ramp[GRADE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fuzzy_oa_if.sv -----
// ----------------------------------------------------------------------------
// fuzzy_oa_if
// Valid/ready channels for distance samples and wheel speed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fuzzy_oa_in_if;
    import fuzzy_oa_pkg::*;
    logic  valid;
    logic  ready;
    dist_t left_distance;
    dist_t right_distance;
    dist_t front_distance;
    dist_t rear_distance;

    modport source (output valid, left_distance, right_distance, front_distance,
                    rear_distance, input ready);
    modport sink   (input valid, left_distance, right_distance, front_distance,
                    rear_distance, output ready);
endinterface

interface fuzzy_oa_out_if;
    import fuzzy_oa_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [WHEEL_W-1:0]  left_wheel_speed;
    logic signed [WHEEL_W-1:0]  right_wheel_speed;
    logic signed [FWD_W-1:0]    forward_speed;
    logic signed [TURN_W-1:0]   turn_rate;

    modport source (output valid, left_wheel_speed, right_wheel_speed, forward_speed,
                    turn_rate, input ready);
    modport sink   (input valid, left_wheel_speed, right_wheel_speed, forward_speed,
                    turn_rate, output ready);
endinterface

`default_nettype wire

// ----- rtl/fuzzy_obstacle_avoidance_core.sv -----
// ----------------------------------------------------------------------------
// fuzzy_obstacle_avoidance_core
// Zero-order fuzzy controller mapping four obstacle distances to wheel speeds.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one beat of four unsigned Q4.8 distances (left, right,
//   front, rear). result carries one beat per sample: left and right wheel
//   speeds, forward speed and turn rate, all signed with 12 fraction bits.
//   Both channels are valid/ready; a beat moves when both are high.
//   Throughput: one sample per cycle, sustained while result.ready stays high.
//   A sample passes three front stages (grading, rule min, weighted sums),
//   the queue, and the back pipeline of one entry stage, twelve divider
//   stages and two output stages before its result is valid.
//   The divider resolves one quotient bit per stage for both wheels.
//   When result is stalled the back part holds; a four-beat queue absorbs
//   front beats until it fills, then sample.ready drops.
//   Reset clears all valid bits and the queue; no result is shown until
//   a sample arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_obstacle_avoidance_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    fuzzy_oa_in_if.sink   sample,
    fuzzy_oa_out_if.source result
);
    import fuzzy_oa_pkg::*;

    logic  push_valid, push_ready;
    logic  pop_valid, pop_ready;
    sums_t push_data, pop_data;

    fuzzy_oa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    fuzzy_oa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    fuzzy_oa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

`default_nettype wire

// ----- rtl/fuzzy_oa_front.sv -----
// ----------------------------------------------------------------------------
// fuzzy_oa_front
// Grades the four distances, fires the sixteen rules and accumulates the
// weighted sums; three register stages, stalls only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_oa_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    fuzzy_oa_in_if.sink               sample,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output fuzzy_oa_pkg::sums_t       push_data
);
    import fuzzy_oa_pkg::*;

    logic   en;
    dist_t  dist_in [SENSORS];
    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg;
    grade_t near_reg [SENSORS];
    grade_t w_next [RULES];
    grade_t w_reg  [RULES];
    num_t   part_l_next [4];
    num_t   part_r_next [4];
    den_t   part_d_next [4];
    num_t   part_l_reg  [4];
    num_t   part_r_reg  [4];
    den_t   part_d_reg  [4];
    den_t   den_sum;

    // advance unless the last stage holds a beat the queue cannot take
    assign en           = !s3_valid_reg || push_ready;
    assign sample.ready = en;

    assign dist_in[0] = sample.left_distance;
    assign dist_in[1] = sample.right_distance;
    assign dist_in[2] = sample.front_distance;
    assign dist_in[3] = sample.rear_distance;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= sample.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // rule strengths: min over the four selected grades
    always_comb
    begin
        grade_t g;
        grade_t m;
        logic [3:0] idx;
        for (int i = 0; i < RULES; i++)
        begin
            idx = 4'(i);
            m   = GRADE_ONE;
            for (int k = 0; k < SENSORS; k++)
            begin
                g = idx[3-k] ? near_reg[k] : GRADE_ONE - near_reg[k];
                if (g < m)
                    m = g;
            end
            w_next[i] = m;
        end
    end

    // products with the consequents, summed in groups of four
    always_comb
    begin
        for (int grp = 0; grp < 4; grp++)
        begin
            part_l_next[grp] = '0;
            part_r_next[grp] = '0;
            part_d_next[grp] = '0;
            for (int j = 0; j < 4; j++)
            begin
                part_l_next[grp] = part_l_next[grp]
                    + NUM_W'($signed({1'b0, w_reg[grp*4+j]})) * NUM_W'(LEFT_TABLE[grp*4+j]);
                part_r_next[grp] = part_r_next[grp]
                    + NUM_W'($signed({1'b0, w_reg[grp*4+j]})) * NUM_W'(RIGHT_TABLE[grp*4+j]);
                part_d_next[grp] = part_d_next[grp] + DEN_W'(w_reg[grp*4+j]);
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SENSORS; k++)
                near_reg[k] <= near_grade(dist_in[k]);
            for (int i = 0; i < RULES; i++)
                w_reg[i] <= w_next[i];
            for (int grp = 0; grp < 4; grp++)
            begin
                part_l_reg[grp] <= part_l_next[grp];
                part_r_reg[grp] <= part_r_next[grp];
                part_d_reg[grp] <= part_d_next[grp];
            end
        end
    end

    // final sums, divisor kept at one half or more
    assign den_sum = part_d_reg[0] + part_d_reg[1] + part_d_reg[2] + part_d_reg[3];
    assign push_valid      = s3_valid_reg;
    assign push_data.num_l = part_l_reg[0] + part_l_reg[1] + part_l_reg[2] + part_l_reg[3];
    assign push_data.num_r = part_r_reg[0] + part_r_reg[1] + part_r_reg[2] + part_r_reg[3];
    assign push_data.den   = (den_sum < MIN_DEN) ? MIN_DEN : den_sum;

endmodule

`default_nettype wire

// ----- rtl/fuzzy_oa_queue.sv -----
// ----------------------------------------------------------------------------
// fuzzy_oa_queue
// Four-entry queue of accumulated sums between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_oa_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire fuzzy_oa_pkg::sums_t  push_data,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output fuzzy_oa_pkg::sums_t       pop_data
);
    import fuzzy_oa_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    sums_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- rtl/fuzzy_oa_back.sv -----
// ----------------------------------------------------------------------------
// fuzzy_oa_back
// Divides both weighted sums in a restoring pipeline, one quotient bit per
// stage, then forms forward speed and turn rate into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_oa_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire fuzzy_oa_pkg::sums_t  pop_data,
    fuzzy_oa_out_if.source            result
);
    import fuzzy_oa_pkg::*;

    logic                       en;
    logic                       valid_reg  [DIV_STAGES+1];
    logic [MAG_W-1:0]           rem_l_reg  [DIV_STAGES+1];
    logic [MAG_W-1:0]           rem_r_reg  [DIV_STAGES+1];
    logic [Q_W-1:0]             q_l_reg    [DIV_STAGES+1];
    logic [Q_W-1:0]             q_r_reg    [DIV_STAGES+1];
    den_t                       den_reg    [DIV_STAGES+1];
    logic                       neg_l_reg  [DIV_STAGES+1];
    logic                       neg_r_reg  [DIV_STAGES+1];
    logic                       post_valid_reg;
    logic signed [WHEEL_W-1:0]  l_reg, r_reg, l_next, r_next;
    logic                       out_valid_reg;
    logic signed [WHEEL_W-1:0]  out_l_reg, out_r_reg;
    logic signed [FWD_W-1:0]    fwd_reg, fwd_next;
    logic signed [TURN_W-1:0]   turn_reg, turn_next;
    logic signed [FWD_W:0]      fwd_wide;
    logic signed [WHEEL_W+2:0]  diff;
    logic signed [WHEEL_W+7:0]  prod, adj, tq;

    // whole back part moves when the output register is free or drained
    assign en        = !out_valid_reg || result.ready;
    assign pop_ready = en;

    // valid bits through all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
                valid_reg[s] <= 1'b0;
            post_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= pop_valid;
            for (int s = 0; s < DIV_STAGES; s++)
                valid_reg[s+1] <= valid_reg[s];
            post_valid_reg <= valid_reg[DIV_STAGES];
            out_valid_reg  <= post_valid_reg;
        end
    end

    // entry stage: magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_l_reg[0] <= pop_data.num_l[NUM_W-1];
            neg_r_reg[0] <= pop_data.num_r[NUM_W-1];
            rem_l_reg[0] <= pop_data.num_l[NUM_W-1] ? MAG_W'(-pop_data.num_l)
                                                    : MAG_W'(pop_data.num_l);
            rem_r_reg[0] <= pop_data.num_r[NUM_W-1] ? MAG_W'(-pop_data.num_r)
                                                    : MAG_W'(pop_data.num_r);
            q_l_reg[0]   <= '0;
            q_r_reg[0]   <= '0;
            den_reg[0]   <= pop_data.den;
        end
    end

    // restoring division, stage s settles quotient bit Q_W-1-s
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic [MAG_W-1:0] dshift;
        logic             take_l, take_r;
        assign dshift = MAG_W'(den_reg[s]) << (Q_W - 1 - s);
        assign take_l = (rem_l_reg[s] >= dshift);
        assign take_r = (rem_r_reg[s] >= dshift);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_l_reg[s+1] <= take_l ? rem_l_reg[s] - dshift : rem_l_reg[s];
                rem_r_reg[s+1] <= take_r ? rem_r_reg[s] - dshift : rem_r_reg[s];
                q_l_reg[s+1]   <= q_l_reg[s] | (Q_W'(take_l) << (Q_W - 1 - s));
                q_r_reg[s+1]   <= q_r_reg[s] | (Q_W'(take_r) << (Q_W - 1 - s));
                den_reg[s+1]   <= den_reg[s];
                neg_l_reg[s+1] <= neg_l_reg[s];
                neg_r_reg[s+1] <= neg_r_reg[s];
            end
        end
    end

    // signed wheel speeds, truncated toward zero
    assign l_next = neg_l_reg[DIV_STAGES] ? -WHEEL_W'(q_l_reg[DIV_STAGES])
                                          : WHEEL_W'(q_l_reg[DIV_STAGES]);
    assign r_next = neg_r_reg[DIV_STAGES] ? -WHEEL_W'(q_r_reg[DIV_STAGES])
                                          : WHEEL_W'(q_r_reg[DIV_STAGES]);

    // forward speed and turn rate (times 25 over 8, toward zero), saturated
    always_comb
    begin
        fwd_wide = ((FWD_W+1)'(l_reg) + (FWD_W+1)'(r_reg)) <<< 1;
        if (fwd_wide > (FWD_W+1)'(FWD_MAX))
            fwd_next = FWD_MAX;
        else if (fwd_wide < (FWD_W+1)'(FWD_MIN))
            fwd_next = FWD_MIN;
        else
            fwd_next = FWD_W'(fwd_wide);

        diff = (WHEEL_W+3)'(r_reg) - (WHEEL_W+3)'(l_reg);
        prod = ((WHEEL_W+8)'(diff) <<< 4) + ((WHEEL_W+8)'(diff) <<< 3) + (WHEEL_W+8)'(diff);
        adj  = prod[WHEEL_W+7] ? prod + (WHEEL_W+8)'(7) : prod;
        tq   = adj >>> 3;
        if (tq > (WHEEL_W+8)'(TURN_MAX))
            turn_next = TURN_MAX;
        else if (tq < (WHEEL_W+8)'(TURN_MIN))
            turn_next = TURN_MIN;
        else
            turn_next = TURN_W'(tq);
    end

    // wheel register and output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg     <= l_next;
            r_reg     <= r_next;
            out_l_reg <= l_reg;
            out_r_reg <= r_reg;
            fwd_reg   <= fwd_next;
            turn_reg  <= turn_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.left_wheel_speed  = out_l_reg;
    assign result.right_wheel_speed = out_r_reg;
    assign result.forward_speed     = fwd_reg;
    assign result.turn_rate         = turn_reg;

endmodule

`default_nettype wire
